// ===== rtl/core/tscw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the text screen writer.
`timescale 1ns / 1ps

package tscw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int FCNT_W  = $clog2(COLUMNS + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [FCNT_W-1:0] fcnt_t;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] BLANK_ATTR = 8'h0F;
  localparam logic [7:0] TITLE_ATTR = 8'h1F;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_READ = 2'd1,
    CMD_SET  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAB,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic clr_we;
    logic exec;
    logic fill_we;
    logic copy_step;
    logic copy_drain;
    logic result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic put_tab;
    logic put_scroll;
    logic scroll_pend;
    logic fill_last;
    logic copy_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/tscw_datapath.sv =====
// Screen memory, cursor, fill and scroll pointers, and result registers.
`timescale 1ns / 1ps

module tscw_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tscw_pkg::dp_cmd_t   ctl,
  output tscw_pkg::dp_stat_t  stat,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic [1:0]          cmd,
  input  logic [7:0]          char_code,
  input  logic [4:0]          target_row,
  input  logic [6:0]          target_col,
  output logic                status,
  output logic [6:0]          cursor_col,
  output logic [4:0]          cursor_row,
  output logic [7:0]          cell_char,
  output logic [7:0]          cell_attr,
  output logic                scrolled
);

  logic [15:0]        mem [tscw_pkg::CELLS];
  logic [15:0]        rd_data;

  logic [7:0]         text_attr;
  logic [6:0]         cur_col;
  logic [4:0]         cur_row;
  tscw_pkg::addr_t    clr_addr;
  tscw_pkg::addr_t    fill_addr;
  tscw_pkg::fcnt_t    fill_cnt;
  logic               fill_blank;
  tscw_pkg::addr_t    copy_ptr;
  tscw_pkg::addr_t    pend_addr;
  logic               copy_pend;
  logic               res_status;
  logic               res_read;
  logic               res_scroll;

  logic [7:0]         col_ext;
  logic [7:0]         put_col;
  logic [5:0]         put_row;
  logic               put_scroll;
  logic               is_put;
  logic               is_read;
  logic               is_set;
  logic               is_plain;
  logic               read_ok;
  logic               set_ok;
  tscw_pkg::addr_t    cur_addr;
  tscw_pkg::addr_t    tgt_addr;
  logic [7:0]         tab_rem;
  logic [7:0]         tab_base;
  tscw_pkg::fcnt_t    tab_cnt;
  logic               we;
  tscw_pkg::addr_t    wa;
  logic [15:0]        wd;
  logic               re;
  tscw_pkg::addr_t    ra;

  assign is_put   = (cmd == tscw_pkg::CMD_PUT);
  assign is_read  = (cmd == tscw_pkg::CMD_READ);
  assign is_set   = (cmd == tscw_pkg::CMD_SET);
  assign is_plain = !(char_code inside {tscw_pkg::CH_BS, tscw_pkg::CH_TAB,
                                        tscw_pkg::CH_LF, tscw_pkg::CH_CR});

  assign read_ok = ({1'b0, target_row} < 6'(tscw_pkg::ROWS)) &&
                   ({1'b0, target_col} < 8'(tscw_pkg::COLUMNS));
  assign set_ok  = (({1'b0, target_row} + 6'd1) < 6'(tscw_pkg::ROWS)) &&
                   ({1'b0, target_col} < 8'(tscw_pkg::COLUMNS));

  assign cur_addr = tscw_pkg::addr_t'(cur_row) * tscw_pkg::addr_t'(tscw_pkg::COLUMNS) +
                    tscw_pkg::addr_t'(cur_col);
  assign tgt_addr = tscw_pkg::addr_t'(target_row) * tscw_pkg::addr_t'(tscw_pkg::COLUMNS) +
                    tscw_pkg::addr_t'(target_col);

  // cursor after a put, before it is stored
  always_comb begin
    col_ext    = {1'b0, cur_col};
    put_col    = col_ext;
    put_row    = {1'b0, cur_row};
    put_scroll = 1'b0;
    unique case (char_code)
      tscw_pkg::CH_LF:  put_row = put_row + 6'd1;
      tscw_pkg::CH_CR:  put_col = '0;
      tscw_pkg::CH_BS:  if (cur_col != '0) put_col = col_ext - 8'd1;
      tscw_pkg::CH_TAB: put_col = (col_ext + 8'd8) & ~8'd7;
      default:          put_col = col_ext + 8'd1;
    endcase
    if (put_col >= 8'(tscw_pkg::COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 6'd1;
    end
    if (put_row >= 6'(tscw_pkg::ROWS)) begin
      put_row    = 6'(tscw_pkg::ROWS - 1);
      put_scroll = 1'b1;
    end
  end

  // tab writes up to the next multiple of 8, clipped at the row end
  assign tab_rem  = 8'(tscw_pkg::COLUMNS) - col_ext;
  assign tab_base = 8'd8 - {5'd0, cur_col[2:0]};
  assign tab_cnt  = (tab_rem < tab_base) ? tscw_pkg::fcnt_t'(tab_rem)
                                         : tscw_pkg::fcnt_t'(tab_base);

  always_comb begin
    we = 1'b0;
    wa = cur_addr;
    wd = {text_attr, char_code};
    if (ctl.clr_we) begin
      we = 1'b1;
      wa = clr_addr;
      wd = {(clr_addr < tscw_pkg::addr_t'(tscw_pkg::COLUMNS)) ? tscw_pkg::TITLE_ATTR
                                                               : tscw_pkg::BLANK_ATTR,
            tscw_pkg::SPACE_CHAR};
    end else if (ctl.exec && is_put && is_plain) begin
      we = 1'b1;
    end else if (ctl.fill_we) begin
      we = 1'b1;
      wa = fill_addr;
      wd = {fill_blank ? tscw_pkg::BLANK_ATTR : text_attr, tscw_pkg::SPACE_CHAR};
    end else if (copy_pend) begin
      we = 1'b1;
      wa = pend_addr;
      wd = rd_data;
    end
  end

  assign re = ctl.copy_step || (ctl.exec && is_read && read_ok);
  assign ra = ctl.copy_step ? copy_ptr : tgt_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= tscw_pkg::BLANK_ATTR;
      cur_col   <= '0;
      cur_row   <= 5'd1;
      clr_addr  <= '0;
      copy_pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_attr <= cfg_data;
      end
      if (ctl.clr_we) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (ctl.exec && is_put) begin
        cur_col <= put_col[6:0];
        cur_row <= put_row[4:0];
      end else if (ctl.exec && is_set && set_ok) begin
        cur_col <= target_col;
        cur_row <= target_row + 5'd1;
      end
      if (ctl.copy_step) begin
        copy_pend <= 1'b1;
      end else if (ctl.copy_drain) begin
        copy_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_status <= (is_read && !read_ok) || (is_set && !set_ok);
      res_read   <= is_read && read_ok;
      res_scroll <= is_put && put_scroll;
      fill_addr  <= cur_addr;
      fill_cnt   <= tab_cnt;
      fill_blank <= 1'b0;
      copy_ptr   <= tscw_pkg::addr_t'(2 * tscw_pkg::COLUMNS);
    end else if (ctl.copy_drain) begin
      fill_addr  <= tscw_pkg::addr_t'((tscw_pkg::ROWS - 1) * tscw_pkg::COLUMNS);
      fill_cnt   <= tscw_pkg::fcnt_t'(tscw_pkg::COLUMNS);
      fill_blank <= 1'b1;
    end else if (ctl.fill_we) begin
      fill_addr <= fill_addr + 1'b1;
      fill_cnt  <= fill_cnt - 1'b1;
    end
    if (ctl.copy_step) begin
      copy_ptr  <= copy_ptr + 1'b1;
      pend_addr <= copy_ptr - tscw_pkg::addr_t'(tscw_pkg::COLUMNS);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      status     <= res_status;
      cursor_col <= cur_col;
      cursor_row <= cur_row;
      cell_char  <= res_read ? rd_data[7:0] : 8'd0;
      cell_attr  <= res_read ? rd_data[15:8] : 8'd0;
      scrolled   <= res_scroll;
    end
  end

  assign stat.clr_last    = (clr_addr == tscw_pkg::addr_t'(tscw_pkg::CELLS - 1));
  assign stat.put_tab     = is_put && (char_code == tscw_pkg::CH_TAB);
  assign stat.put_scroll  = is_put && put_scroll;
  assign stat.scroll_pend = res_scroll;
  assign stat.fill_last   = (fill_cnt == tscw_pkg::fcnt_t'(1));
  assign stat.copy_last   = (copy_ptr == tscw_pkg::addr_t'(tscw_pkg::CELLS - 1));

endmodule

// ===== rtl/core/tscw_ctrl.sv =====
// Sequencing state machine and channel handshakes for the text screen writer.
`timescale 1ns / 1ps

module tscw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tscw_pkg::dp_stat_t  stat,
  output tscw_pkg::dp_cmd_t   ctl
);

  tscw_pkg::ctl_state_t state, state_next;
  logic                 out_valid_next;
  logic                 slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != tscw_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tscw_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl            = '0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      tscw_pkg::ST_CLEAR: begin
        ctl.clr_we = 1'b1;
        if (stat.clr_last) state_next = tscw_pkg::ST_IDLE;
      end
      tscw_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.exec = 1'b1;
          if (stat.put_tab) begin
            state_next = tscw_pkg::ST_TAB;
          end else if (stat.put_scroll) begin
            state_next = tscw_pkg::ST_COPY;
          end else begin
            state_next = tscw_pkg::ST_DONE;
          end
        end
      end
      tscw_pkg::ST_TAB: begin
        ctl.fill_we = 1'b1;
        if (stat.fill_last) begin
          state_next = stat.scroll_pend ? tscw_pkg::ST_COPY : tscw_pkg::ST_DONE;
        end
      end
      tscw_pkg::ST_COPY: begin
        ctl.copy_step = 1'b1;
        if (stat.copy_last) state_next = tscw_pkg::ST_DRAIN;
      end
      tscw_pkg::ST_DRAIN: begin
        ctl.copy_drain = 1'b1;
        state_next     = tscw_pkg::ST_BLANK;
      end
      tscw_pkg::ST_BLANK: begin
        ctl.fill_we = 1'b1;
        if (stat.fill_last) state_next = tscw_pkg::ST_DONE;
      end
      tscw_pkg::ST_DONE: begin
        if (slot_free) begin
          ctl.result_load = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = tscw_pkg::ST_IDLE;
        end
      end
      default: state_next = tscw_pkg::ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/core/text_screen_char_writer_top.sv =====
// Top level of the text screen writer: controller plus screen datapath.
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall | cmd, char_code, target_row, target_col
//   out     | out_valid/out_stall | status, cursor_col, cursor_row, cell_char,
//           |                     | cell_attr, scrolled
//   cfg     | cfg_we              | cfg_data (text attribute)
//
// Put, read, set and unused commands are accepted, then their result is loaded.
// A tab also writes its spaces (1 to 8) through the single write port.
// A scroll also copies 1840 cells up one row (one cell read and one written
// per cycle), then drains the last copy and blanks the bottom row's 80 cells.
// After rst all 2000 screen cells are cleared while in_stall is high.
// A result held by out_stall lets the next item in; it then waits at result load.
`timescale 1ns / 1ps

module text_screen_char_writer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [4:0]  target_row,
  input  logic [6:0]  target_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  output logic        scrolled
);

  tscw_pkg::dp_cmd_t  ctl;
  tscw_pkg::dp_stat_t stat;

  tscw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  tscw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .char_code  (char_code),
    .target_row (target_row),
    .target_col (target_col),
    .status     (status),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .scrolled   (scrolled)
  );

endmodule

// ===== rtl/core/tscw_checker.sv =====
// Port-level checks for the text screen writer, bound to the top level.
`timescale 1ns / 1ps

module tscw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic [6:0]  cursor_col,
  input logic [4:0]  cursor_row,
  input logic [7:0]  cell_char,
  input logic [7:0]  cell_attr,
  input logic        scrolled
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(cursor_col) &&
      $stable(cursor_row) && $stable(cell_char) && $stable(cell_attr) && $stable(scrolled))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_col < 7'(tscw_pkg::COLUMNS)) && (cursor_row != 5'd0) &&
      (cursor_row < 5'(tscw_pkg::ROWS)))
    else $error("cursor outside the text area");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> (cursor_row == 5'(tscw_pkg::ROWS - 1)) && !status)
    else $error("scroll left cursor off the bottom row");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (cell_char == 8'd0) && (cell_attr == 8'd0) && !scrolled)
    else $error("rejected item carries cell data");

endmodule

bind text_screen_char_writer_top tscw_checker u_tscw_checker (.*);
